// File: hw/rtl/bde_pkg.sv
// bde_pkg: shared types and constants for the bounded deque engine
// used by bde_cell and bounded_deque_engine; no dependencies
package bde_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DUMP       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT_FRONT,
    CELL_WRITE_BACK,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic [1:0]               status;
    logic                     last_of_run;
  } out_t;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [WORD_W-1:0] wdata;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/bde_cell.sv
// bde_cell: one storage cell of the deque row, holds one word
// depends on bde_pkg
module bde_cell #(
  parameter int unsigned CAPACITY = bde_pkg::DEF_CAPACITY,
  parameter int unsigned IDX      = 0
) (
  input  logic                                     clk_i,
  input  bde_pkg::cell_ctrl_t                      ctrl_i,
  input  logic [$clog2(CAPACITY+1)-1:0]            count_i,
  input  logic signed [bde_pkg::WORD_W-1:0]        left_i,
  input  logic signed [bde_pkg::WORD_W-1:0]        right_i,
  input  logic signed [bde_pkg::WORD_W-1:0]        head_i,
  output logic signed [bde_pkg::WORD_W-1:0]        data_o,
  output logic signed [bde_pkg::WORD_W-1:0]        tail_o
);
  import bde_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] IdxCnt  = CntW'(IDX);
  localparam logic [CntW-1:0] LastCnt = CntW'(IDX + 1);

  logic signed [WORD_W-1:0] data_q, data_d;
  logic                     is_last;

  assign is_last = (count_i == LastCnt);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_HOLD:         data_d = data_q;
      CELL_INSERT_FRONT: data_d = (IDX == 0) ? ctrl_i.wdata : left_i;
      CELL_WRITE_BACK:   data_d = (count_i == IdxCnt) ? ctrl_i.wdata : data_q;
      // last occupied cell takes the head so the ring closes
      CELL_ROTATE:       data_d = is_last ? head_i : right_i;
      default:           data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tail_o = is_last ? data_q : '0;

endmodule

// File: hw/rtl/bounded_deque_engine.sv
// bounded_deque_engine: top level, row of bde_cell plus request control
// depends on bde_pkg and bde_cell
//
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_i): one request, kind and value
//   out channel (out_valid_o / out_ready_i / out_o): result words
//   The front element always sits in cell 0; occupied cells are 0..count-1.
//   Push and pop requests are accepted back to back while the receiver keeps up;
//   the result is registered and shows in the cycle after the request.
//   Pop back reads the last occupied cell through a one-hot select of the row.
//   A dump rotates the row left once per emitted element, so it holds off new
//   requests until its last element is emitted (later if the receiver stalls)
//   and leaves the order as it was. An empty dump gives one empty result.
//   Unused kinds are accepted and produce nothing.
//   When the receiver stalls, the result waits in the output register and
//   in_ready_o drops until that register can be reloaded.
//   Reset empties the deque (count zero); cell contents are not cleared and
//   need no clearing pass.
module bounded_deque_engine #(
  parameter int unsigned CAPACITY = bde_pkg::DEF_CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bde_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bde_pkg::out_t out_o
);
  import bde_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      remain_q, remain_d;
  out_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic                 out_free;
  logic                 accept;
  cell_ctrl_t           ctrl;
  logic signed [WORD_W-1:0] cell_data [CAPACITY];
  logic signed [WORD_W-1:0] cell_tail [CAPACITY];
  logic signed [WORD_W-1:0] left_w    [CAPACITY];
  logic signed [WORD_W-1:0] right_w   [CAPACITY];
  logic signed [WORD_W-1:0] tail_sel;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_inner_l
      assign left_w[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w[i] = '0;
    end else begin : g_inner_r
      assign right_w[i] = cell_data[i+1];
    end

    bde_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i]),
      .tail_o  (cell_tail[i])
    );
  end

  // only the last occupied cell drives a nonzero tail
  always_comb begin
    tail_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_sel = tail_sel | cell_tail[i];
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    remain_d   = remain_q;
    ctrl.op    = CELL_HOLD;
    ctrl.wdata = in_i.value;
    out_load   = 1'b0;
    out_d.result_value = '0;
    out_d.status       = STATUS_OK;
    out_d.last_of_run  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_e'(in_i.kind))
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              out_load = 1'b1;
              if (count_q == FullCnt) begin
                out_d.status = STATUS_FULL;
              end else begin
                ctrl.op = (kind_e'(in_i.kind) == KIND_PUSH_FRONT) ?
                          CELL_INSERT_FRONT : CELL_WRITE_BACK;
                count_d = count_q + OneCnt;
              end
            end
            KIND_POP_FRONT: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                out_d.status = STATUS_EMPTY;
              end else begin
                out_d.result_value = cell_data[0];
                ctrl.op = CELL_ROTATE;
                count_d = count_q - OneCnt;
              end
            end
            KIND_POP_BACK: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                out_d.status = STATUS_EMPTY;
              end else begin
                out_d.result_value = tail_sel;
                count_d = count_q - OneCnt;
              end
            end
            KIND_DUMP: begin
              if (count_q == '0) begin
                out_load     = 1'b1;
                out_d.status = STATUS_EMPTY;
              end else begin
                state_d  = ST_DUMP;
                remain_d = count_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_d.result_value = cell_data[0];
          out_d.last_of_run  = (remain_q == OneCnt);
          ctrl.op            = CELL_ROTATE;
          remain_d           = remain_q - OneCnt;
          if (remain_q == OneCnt) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("element count above capacity");

  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> !in_ready_o)
    else $error("request taken during dump");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && out_free && remain_q == OneCnt) |=> (state_q == ST_IDLE))
    else $error("dump did not finish after last element");

  a_dump_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> $stable(count_q))
    else $error("count changed during dump");

endmodule

// File: bench/bounded_deque_engine_tb.sv
// bounded_deque_engine_tb: self-checking bench for the bounded deque engine, a directed
// table followed by random bursts, results checked against a local ring model or typed answers
// depends on bde_pkg and bounded_deque_engine
module bounded_deque_engine_tb;
  import bde_pkg::*;

  localparam int unsigned CAP          = DEF_CAPACITY;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * CAP + 4;
  localparam int unsigned IDLE_PCT     = 24;
  localparam int unsigned QUIET_FIRST  = 200;
  localparam int unsigned QUIET_LAST   = 280;

  localparam logic [2:0] KIND_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] KIND_MID_UNUSED   = 3'd6;
  localparam logic [2:0] KIND_LAST_UNUSED  = 3'd7;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED,
    MODE_NOISE
  } burst_mode_e;

  typedef struct {
    in_t     req;
    int      reps;
    bit      typed;
    status_e typed_status;
  } step_row_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  in_t   in_data;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  // ring model of the deque
  logic signed [WORD_W-1:0] ring_words [CAP];
  int unsigned ring_front;
  int unsigned ring_count;

  out_t        deque_results [$];
  out_t        mon_want;
  step_row_t   step_table [$];
  bit          quiet;
  int unsigned n_errors;
  int unsigned n_requests;
  int unsigned n_ignored;
  int unsigned n_results;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned cycle_count;

  bounded_deque_engine #(
    .CAPACITY(CAP)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, deque_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_data.status == STATUS_FULL) n_full++;
      if (out_data.status == STATUS_EMPTY) n_empty++;
      if (deque_results.size() == 0) begin
        $display("%0t: unexpected result, actual value %h status %0d last %0b",
                 $time, out_data.result_value, out_data.status, out_data.last_of_run);
        n_errors++;
      end else begin
        mon_want = deque_results.pop_front();
        if (out_data.result_value !== mon_want.result_value) begin
          $display("%0t: result_value expected %h actual %h",
                   $time, mon_want.result_value, out_data.result_value);
          n_errors++;
        end
        if (out_data.status !== mon_want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, mon_want.status, out_data.status);
          n_errors++;
        end
        if (out_data.last_of_run !== mon_want.last_of_run) begin
          $display("%0t: last_of_run expected %0b actual %0b",
                   $time, mon_want.last_of_run, out_data.last_of_run);
          n_errors++;
        end
      end
    end
  end

  task automatic model_request(input in_t req);
    out_t        r;
    int unsigned k;
    r = '{result_value: '0, status: STATUS_OK, last_of_run: 1'b1};
    case (req.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (ring_count >= CAP) begin
          r.status = STATUS_FULL;
        end else begin
          if (req.kind == KIND_PUSH_FRONT) begin
            ring_front = (ring_front + CAP - 1) % CAP;
            ring_words[ring_front] = req.value;
          end else begin
            ring_words[(ring_front + ring_count) % CAP] = req.value;
          end
          ring_count++;
        end
        deque_results.push_back(r);
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (ring_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          if (req.kind == KIND_POP_FRONT) begin
            r.result_value = ring_words[ring_front];
            ring_front = (ring_front + 1) % CAP;
          end else begin
            r.result_value = ring_words[(ring_front + ring_count - 1) % CAP];
          end
          ring_count--;
        end
        deque_results.push_back(r);
      end
      KIND_DUMP: begin
        if (ring_count == 0) begin
          r.status = STATUS_EMPTY;
          deque_results.push_back(r);
        end else begin
          for (k = 0; k < ring_count; k++) begin
            r.result_value = ring_words[(ring_front + k) % CAP];
            r.last_of_run  = (k + 1 == ring_count);
            deque_results.push_back(r);
          end
        end
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic send_request(input in_t req, input bit typed, input status_e typed_status);
    out_t r;
    // idle at random so about a quarter of the cycles carry no request
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_requests++;
    model_request(req);
    // directed rows marked typed carry their answer typed in
    if (typed) begin
      void'(deque_results.pop_back());
      r = '{result_value: '0, status: typed_status, last_of_run: 1'b1};
      deque_results.push_back(r);
    end
    @(negedge clk);
  endtask

  function automatic step_row_t mk_row(input logic [2:0] kind, input logic [31:0] value,
                                       input int reps, input bit typed, input status_e st);
    step_row_t row;
    row.req.kind     = kind;
    row.req.value    = value;
    row.reps         = reps;
    row.typed        = typed;
    row.typed_status = st;
    return row;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_request(input burst_mode_e mode);
    in_t         req;
    int unsigned roll;
    int unsigned push_lim;
    int unsigned pop_lim;
    int unsigned dump_lim;
    case (mode)
      MODE_FILL:  begin push_lim = 70; pop_lim = 90; dump_lim = 100; end
      MODE_DRAIN: begin push_lim = 20; pop_lim = 90; dump_lim = 100; end
      MODE_MIXED: begin push_lim = 40; pop_lim = 85; dump_lim = 100; end
      default:    begin push_lim = 30; pop_lim = 60; dump_lim = 70;  end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_lim) begin
      req.kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    end else if (roll < pop_lim) begin
      req.kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
    end else if (roll < dump_lim) begin
      req.kind = KIND_DUMP;
    end else begin
      req.kind = 3'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
    end
    req.value = pick_word();
    return req;
  endfunction

  initial begin
    in_t         req;
    burst_mode_e mode;
    int unsigned n_counted;
    int unsigned burst_len;
    int unsigned j;
    int          r;
    int unsigned pick;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    ring_front  = 0;
    ring_count  = 0;
    n_errors    = 0;
    n_requests  = 0;
    n_ignored   = 0;
    n_results   = 0;
    n_full      = 0;
    n_empty     = 0;
    cycle_count = 0;
    n_counted   = 0;

    step_table.push_back(mk_row(KIND_POP_FRONT,  32'h0000_0000, 1, 1'b1, STATUS_EMPTY));
    step_table.push_back(mk_row(KIND_POP_BACK,   32'hffff_ffff, 1, 1'b1, STATUS_EMPTY));
    step_table.push_back(mk_row(KIND_DUMP,       32'h1234_5678, 1, 1'b1, STATUS_EMPTY));
    step_table.push_back(mk_row(KIND_PUSH_BACK,  32'h7fff_ffff, 1, 1'b1, STATUS_OK));
    step_table.push_back(mk_row(KIND_PUSH_FRONT, 32'h8000_0000, 1, 1'b1, STATUS_OK));
    step_table.push_back(mk_row(KIND_PUSH_BACK,  32'h0000_0000, 1, 1'b1, STATUS_OK));
    step_table.push_back(mk_row(KIND_PUSH_FRONT, 32'hffff_ffff, 1, 1'b1, STATUS_OK));
    step_table.push_back(mk_row(KIND_DUMP,       32'h0000_0000, 1, 1'b0, STATUS_OK));
    step_table.push_back(mk_row(KIND_POP_FRONT,  32'h0000_0000, 1, 1'b0, STATUS_OK));
    step_table.push_back(mk_row(KIND_POP_BACK,   32'h0000_0000, 1, 1'b0, STATUS_OK));
    // unused kinds are dropped without an answer
    step_table.push_back(mk_row(KIND_FIRST_UNUSED, 32'h5555_5555, 1, 1'b0, STATUS_OK));
    step_table.push_back(mk_row(KIND_MID_UNUSED,   32'haaaa_aaaa, 1, 1'b0, STATUS_OK));
    step_table.push_back(mk_row(KIND_LAST_UNUSED,  32'hffff_ffff, 1, 1'b0, STATUS_OK));
    // fill to capacity from both ends, then hit the full refusal
    step_table.push_back(mk_row(KIND_PUSH_FRONT, 32'h1000_0000, 7, 1'b1, STATUS_OK));
    step_table.push_back(mk_row(KIND_PUSH_BACK,  32'h2000_0000, 7, 1'b1, STATUS_OK));
    step_table.push_back(mk_row(KIND_PUSH_FRONT, 32'h0000_0001, 1, 1'b1, STATUS_FULL));
    step_table.push_back(mk_row(KIND_PUSH_BACK,  32'h0000_0002, 1, 1'b1, STATUS_FULL));
    step_table.push_back(mk_row(KIND_DUMP,       32'h0000_0000, 1, 1'b0, STATUS_OK));
    step_table.push_back(mk_row(KIND_POP_BACK,   32'h0000_0000, 8, 1'b0, STATUS_OK));
    step_table.push_back(mk_row(KIND_POP_FRONT,  32'h0000_0000, 8, 1'b0, STATUS_OK));
    step_table.push_back(mk_row(KIND_POP_FRONT,  32'h0000_0000, 1, 1'b1, STATUS_EMPTY));
    step_table.push_back(mk_row(KIND_PUSH_BACK,  32'h0000_ffff, 1, 1'b0, STATUS_OK));
    step_table.push_back(mk_row(KIND_DUMP,       32'h0000_0000, 1, 1'b0, STATUS_OK));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (step_table[i]) begin
      for (r = 0; r < step_table[i].reps; r++) begin
        req = step_table[i].req;
        req.value = req.value + r;
        send_request(req, step_table[i].typed, step_table[i].typed_status);
      end
    end

    while (n_counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) mode = MODE_FILL;
      else if (pick < 6) mode = MODE_DRAIN;
      else if (pick < 9) mode = MODE_MIXED;
      else mode = MODE_NOISE;
      burst_len = $urandom_range(8, 30);
      for (j = 0; j < burst_len && n_counted < RANDOM_ITEMS; j++) begin
        quiet = (n_counted >= QUIET_FIRST) && (n_counted < QUIET_LAST);
        req = random_request(mode);
        send_request(req, 1'b0, STATUS_OK);
        if (req.kind <= KIND_DUMP) n_counted++;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (deque_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d of unused kind) and %0d results",
             n_requests, n_ignored, n_results);
    $display("saw %0d full refusals and %0d empty answers", n_full, n_empty);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
